// ----- rtl/mpa_pkg.sv -----
// Package for the p = 2^255-19 field arithmetic unit.
// Holds the operation codes, limb geometry and the field constants; no dependencies.
package mpa_pkg;

	localparam int LIMB_W  = 64;
	localparam int FE_W    = 256;
	localparam int PROD_W  = 512;
	localparam int RED_W   = 255;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_SQR = 2'd3
	} func_t;

	// The prime p = 2^255 - 19.
	localparam logic [FE_W-1:0] PRIME_P =
		256'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;

	// -p^-1 mod 2^255, which is 19^-1 mod 2^255.
	localparam logic [FE_W-1:0] NEG_PINV =
		256'd21330121701610878104342023554231983025602365596302209165163239159352418617883;

endpackage

// ----- rtl/mod_p25519_arith_unit.sv -----
// Top level of the p = 2^255-19 field arithmetic unit.
// Depends on mpa_pkg and mpa_mul256.
//
// One input channel (in_valid/in_ready) carries func and the operands x and y
// as four 64-bit limbs each; one output channel (out_valid/out_ready) returns
// z as four 64-bit limbs. A beat is moved when valid and ready are both high.
// Add and subtract are modular; multiply and square return the Montgomery
// product with R = 2^255.
// Every operation goes through the same 15 register stages, and a new beat is
// taken every cycle while the receiver does not stall. The depth is set by two
// chained 256 x 256 multipliers of five stages each (the product, then the
// reduction factor), plus the input stage, the stage that forms 19*m, the fold
// T_hi + m - k, the compare against p and the output register that applies the
// correction.
// When the receiver stalls, the whole pipeline holds and in_ready drops while
// a result waits; nothing is lost or repeated. Reset clears all valid bits;
// the unit is ready as soon as reset is released.
module mod_p25519_arith_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [63:0] x_limb0,
	input  logic [63:0] x_limb1,
	input  logic [63:0] x_limb2,
	input  logic [63:0] x_limb3,
	input  logic [63:0] y_limb0,
	input  logic [63:0] y_limb1,
	input  logic [63:0] y_limb2,
	input  logic [63:0] y_limb3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] z_limb0,
	output logic [63:0] z_limb1,
	output logic [63:0] z_limb2,
	output logic [63:0] z_limb3
);

	localparam int FW     = mpa_pkg::FE_W;
	localparam int SIDE1  = 2 + FW + 1;
	localparam int SIDE2  = SIDE1 + FW + 1;

	logic en;
	logic [FW-1:0] x, y;

	// Input stage.
	logic               v_s1;
	mpa_pkg::func_t     func_s1;
	logic [FW-1:0]      a_s1, b_s1;
	logic [FW:0]        raw_s1;

	// After the first multiplier.
	logic                      v_s6;
	logic [mpa_pkg::PROD_W-1:0] t_s6;
	logic [SIDE1-1:0]          side_s6;

	// After the second multiplier.
	logic                      v_s11;
	logic [mpa_pkg::PROD_W-1:0] m_full_s11;
	logic [SIDE2-1:0]          side_s11;

	logic [mpa_pkg::RED_W-1:0] m_w;
	logic [259:0]              m19_w;

	logic               v_s12;
	mpa_pkg::func_t     func_s12;
	logic [mpa_pkg::RED_W-1:0] m_s12;
	logic [4:0]         k_s12;
	logic [FW-1:0]      thi_s12;
	logic [FW:0]        raw_s12;

	logic               v_s13;
	mpa_pkg::func_t     func_s13;
	logic [FW-1:0]      val_s13;
	logic               cy_s13;

	logic               v_s14;
	logic [FW-1:0]      val_s14;
	logic               corr_s14;
	logic               sub_s14;

	logic               v_s15;
	logic [FW-1:0]      z_s15;

	assign en       = !v_s15 || out_ready;
	assign in_ready = en;
	assign x = {x_limb3, x_limb2, x_limb1, x_limb0};
	assign y = {y_limb3, y_limb2, y_limb1, y_limb0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	// Bit 256 of the raw add/sub word is the carry for add and the borrow for subtract.
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= mpa_pkg::func_t'(func);
			a_s1    <= x;
			b_s1    <= (mpa_pkg::func_t'(func) == mpa_pkg::FUNC_SQR) ? x : y;
			if (mpa_pkg::func_t'(func) == mpa_pkg::FUNC_SUB) begin
				raw_s1 <= {1'b0, x} - {1'b0, y};
			end else begin
				raw_s1 <= {1'b0, x} + {1'b0, y};
			end
		end
	end

	mpa_mul256 #(.SIDE_W(SIDE1)) u_mul_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.a         (a_s1),
		.b         (b_s1),
		.side_in   ({func_s1, raw_s1}),
		.out_valid (v_s6),
		.prod      (t_s6),
		.side_out  (side_s6)
	);

	mpa_mul256 #(.SIDE_W(SIDE2)) u_mul_m (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.a         ({1'b0, t_s6[mpa_pkg::RED_W-1:0]}),
		.b         (mpa_pkg::NEG_PINV),
		.side_in   ({side_s6, t_s6[mpa_pkg::PROD_W-1:mpa_pkg::RED_W]}),
		.out_valid (v_s11),
		.prod      (m_full_s11),
		.side_out  (side_s11)
	);

	// Since m*p = m*2^255 - 19*m and 19*m = c + k*2^255 with c the low half of T,
	// the reduced value is T_hi + m - k, where k is the top of 19*m.
	assign m_w   = m_full_s11[mpa_pkg::RED_W-1:0];
	assign m19_w = {5'd0, m_w} + {1'b0, m_w, 4'd0} + {4'd0, m_w, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s12 <= mpa_pkg::func_t'(side_s11[SIDE2-1 -: 2]);
			raw_s12  <= side_s11[SIDE2-3 -: FW+1];
			thi_s12  <= side_s11[FW-1:0];
			m_s12    <= m_w;
			k_s12    <= m19_w[259:255];

			func_s13 <= func_s12;
			if (func_s12 == mpa_pkg::FUNC_ADD || func_s12 == mpa_pkg::FUNC_SUB) begin
				val_s13 <= raw_s12[FW-1:0];
				cy_s13  <= raw_s12[FW];
			end else begin
				val_s13 <= thi_s12 + {1'b0, m_s12} - {251'd0, k_s12};
				cy_s13  <= 1'b0;
			end

			val_s14 <= val_s13;
			sub_s14 <= (func_s13 == mpa_pkg::FUNC_SUB);
			unique case (func_s13)
				mpa_pkg::FUNC_ADD: corr_s14 <= cy_s13 || (val_s13 >= mpa_pkg::PRIME_P);
				mpa_pkg::FUNC_SUB: corr_s14 <= cy_s13;
				default:           corr_s14 <= (val_s13 >= mpa_pkg::PRIME_P);
			endcase

			if (!corr_s14) begin
				z_s15 <= val_s14;
			end else if (sub_s14) begin
				z_s15 <= val_s14 + mpa_pkg::PRIME_P;
			end else begin
				z_s15 <= val_s14 - mpa_pkg::PRIME_P;
			end
		end
	end

	assign out_valid = v_s15;
	assign z_limb0   = z_s15[63:0];
	assign z_limb1   = z_s15[127:64];
	assign z_limb2   = z_s15[191:128];
	assign z_limb3   = z_s15[255:192];

endmodule

// ----- rtl/mpa_mul256.sv -----
// Pipelined 256 x 256 -> 512 bit multiplier built from 32 x 32 partial products.
// Five register stages; carries a sideband word alongside. Uses mpa_pkg.
module mpa_mul256 #(
	parameter int SIDE_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [mpa_pkg::FE_W-1:0]    a,
	input  logic [mpa_pkg::FE_W-1:0]    b,
	input  logic [SIDE_W-1:0]           side_in,
	output logic                        out_valid,
	output logic [mpa_pkg::PROD_W-1:0]  prod,
	output logic [SIDE_W-1:0]           side_out
);

	localparam int NW = mpa_pkg::FE_W / 32;

	logic [63:0]  pp_s1 [NW][NW];
	logic [287:0] row_s2 [NW];
	logic [319:0] quad_s3 [NW/2];
	logic [383:0] half_s4 [NW/4];
	logic [mpa_pkg::PROD_W-1:0] prod_s5;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Even-indexed products of a row sit side by side without overlap, as do odd ones.
	logic [255:0] ev [NW];
	logic [255:0] od [NW];

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			for (int j = 0; j < NW/2; j++) begin
				ev[i][64*j +: 64] = pp_s1[i][2*j];
				od[i][64*j +: 64] = pp_s1[i][2*j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				for (int j = 0; j < NW; j++) begin
					pp_s1[i][j] <= {32'd0, a[32*i +: 32]} * {32'd0, b[32*j +: 32]};
				end
			end
			for (int i = 0; i < NW; i++) begin
				row_s2[i] <= {32'd0, ev[i]} + {od[i], 32'd0};
			end
			for (int k = 0; k < NW/2; k++) begin
				quad_s3[k] <= {32'd0, row_s2[2*k]} + {row_s2[2*k+1], 32'd0};
			end
			for (int k = 0; k < NW/4; k++) begin
				half_s4[k] <= {64'd0, quad_s3[2*k]} + {quad_s3[2*k+1], 64'd0};
			end
			prod_s5 <= {128'd0, half_s4[0]} + {half_s4[1], 128'd0};
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	assign out_valid = v_s5;
	assign prod      = prod_s5;
	assign side_out  = side_s5;

endmodule

// ----- tb/mod_p25519_arith_unit_tb.sv -----
// Self-checking bench for the p = 2^255-19 field arithmetic unit (add, sub, Montgomery mul/sqr).
// Depends on mpa_pkg and the unit's RTL; a wide-integer model predicts every result beat.
module mod_p25519_arith_unit_tb;

	localparam logic [255:0] P = 256'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
	localparam logic [255:0] ONES = {256{1'b1}};
	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM = 1100;

	typedef struct {
		mpa_pkg::func_t op;
		logic [255:0] x;
		logic [255:0] y;
		logic known;
		logic [255:0] z;
	} vec_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] func;
	logic [63:0] x_limb0, x_limb1, x_limb2, x_limb3;
	logic [63:0] y_limb0, y_limb1, y_limb2, y_limb3;
	logic [63:0] z_limb0, z_limb1, z_limb2, z_limb3;

	logic [255:0] pending_z[$];
	int errors = 0;
	int results_seen = 0;
	int ops_sent[4] = '{0, 0, 0, 0};
	bit long_hold_req = 0;
	bit long_hold_done = 0;
	bit drain_done = 0;
	vec_t stim[N_DIRECTED];

	mod_p25519_arith_unit dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	// Field result as the unit computes it, including the single-correction quirks.
	function automatic logic [255:0] field_result(mpa_pkg::func_t op, logic [255:0] x,
			logic [255:0] y);
		logic [256:0] sum;
		logic [511:0] t, mp;
		logic [254:0] m;
		logic [511:0] nr_prod;
		logic [255:0] u;
		case (op)
			mpa_pkg::FUNC_ADD: begin
				sum = {1'b0, x} + {1'b0, y};
				if (sum[256] || sum[255:0] >= P) sum = sum - {1'b0, P};
				return sum[255:0];
			end
			mpa_pkg::FUNC_SUB: begin
				if (x >= y) return x - y;
				return x + P - y;
			end
			default: begin
				t = (op == mpa_pkg::FUNC_MUL) ? {256'd0, x} * {256'd0, y} :
					{256'd0, x} * {256'd0, x};
				nr_prod = {257'd0, t[254:0]} * {256'd0, mpa_pkg::NEG_PINV};
				m = nr_prod[254:0];
				mp = {257'd0, m} * {256'd0, P};
				t = t + mp;
				u = t[510:255];
				if (u >= P) u = u - P;
				return u;
			end
		endcase
	endfunction

	function automatic logic [255:0] rand_fe(int mode);
		logic [255:0] v;
		for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
		case (mode)
			0: v = v % P;
			1: v = P - 1 - {248'd0, v[7:0]};
			2: v = {248'd0, v[7:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_beat(mpa_pkg::func_t op, logic [255:0] x, logic [255:0] y);
		int gap;
		gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
			($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		{x_limb3, x_limb2, x_limb1, x_limb0} <= x;
		{y_limb3, y_limb2, y_limb1, y_limb0} <= y;
		pending_z.push_back(field_result(op, x, y));
		ops_sent[op]++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (pending_z.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
				long_hold_done = 1;
			end
			if ($urandom_range(0, 3) == 0)
				out_ready <= 1'b0;
			else if ($urandom_range(0, 30) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(5, 40)) @(posedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [255:0] got, exp_z;
		if (arst_n && out_valid && out_ready) begin
			got = {z_limb3, z_limb2, z_limb1, z_limb0};
			results_seen++;
			if (pending_z.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				errors++;
			end else begin
				exp_z = pending_z.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i*64 +: 64] !== exp_z[i*64 +: 64]) begin
						$error("z_limb%0d: expected %h, got %h", i, exp_z[i*64 +: 64],
							got[i*64 +: 64]);
						errors++;
					end
			end
		end
	end

	initial begin
		mpa_pkg::func_t op;
		logic [255:0] a, b;
		// Directed rows: extremes and each open case; known results typed in where obvious.
		stim = '{
			'{mpa_pkg::FUNC_ADD, 256'd0, 256'd0, 1, 256'd0},
			'{mpa_pkg::FUNC_ADD, P - 1, 256'd1, 1, 256'd0},
			'{mpa_pkg::FUNC_ADD, P - 1, P - 1, 1, P - 2},
			'{mpa_pkg::FUNC_ADD, ONES, ONES, 0, 0},
			'{mpa_pkg::FUNC_ADD, ONES, 256'd1, 0, 0},
			'{mpa_pkg::FUNC_SUB, 256'd5, 256'd5, 1, 256'd0},
			'{mpa_pkg::FUNC_SUB, 256'd0, 256'd1, 1, P - 1},
			'{mpa_pkg::FUNC_SUB, 256'd0, ONES, 0, 0},
			'{mpa_pkg::FUNC_SUB, ONES, 256'd0, 1, ONES},
			'{mpa_pkg::FUNC_SUB, P - 1, 256'd0, 1, P - 1},
			'{mpa_pkg::FUNC_MUL, 256'd0, P - 1, 1, 256'd0},
			'{mpa_pkg::FUNC_MUL, 256'd1, 256'd1, 0, 0},
			'{mpa_pkg::FUNC_MUL, P - 1, P - 1, 0, 0},
			'{mpa_pkg::FUNC_MUL, ONES, ONES, 0, 0},
			'{mpa_pkg::FUNC_MUL, 256'd1 << 255, 256'd2, 0, 0},
			'{mpa_pkg::FUNC_SQR, 256'd0, ONES, 1, 256'd0},
			'{mpa_pkg::FUNC_SQR, P - 1, 256'd0, 0, 0},
			'{mpa_pkg::FUNC_SQR, ONES, 256'd0, 0, 0},
			'{mpa_pkg::FUNC_SQR, 256'd1 << 255, ONES, 0, 0},
			'{mpa_pkg::FUNC_MUL, P, P, 0, 0}
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = mpa_pkg::FUNC_ADD;
		{x_limb3, x_limb2, x_limb1, x_limb0} = '0;
		{y_limb3, y_limb2, y_limb1, y_limb0} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim[i]) begin
			if (stim[i].known && field_result(stim[i].op, stim[i].x, stim[i].y) !== stim[i].z) begin
				$error("row %0d: expected %h, model gives %h", i, stim[i].z,
					field_result(stim[i].op, stim[i].x, stim[i].y));
				errors++;
			end
			send_beat(stim[i].op, stim[i].x, stim[i].y);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// Mostly in-field operands; some near the edges and some raw 256-bit noise.
			op = mpa_pkg::func_t'($urandom_range(0, 3));
			a = rand_fe($urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 3));
			b = rand_fe($urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 3));
			if (n == 300) long_hold_req = 1;
			if (n == 600) begin
				in_valid <= 1'b0;
				wait_drained();
				drain_done = 1;
			end
			send_beat(op, a, b);
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);

		$display("Sent %0d add, %0d sub, %0d mul, %0d sqr beats; checked %0d results.",
			ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], results_seen);
		$display("Long output hold-off done: %0d, input drain pause done: %0d.",
			long_hold_done, drain_done);
		if (errors == 0 && pending_z.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
